[hw/rtl/isr_pkg.sv]
// shared types and constants of the insertion sort records unit
`default_nettype none

package isr_pkg;

	localparam int MAX_ITEMS  = 32;
	localparam int KEY_W      = 32;
	localparam int ID_W       = 16;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_SORT_BY_FEE = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_DESCENDING  = CFG_IDX_W'(1);

	typedef struct packed {
		logic [KEY_W-1:0] area;
		logic [KEY_W-1:0] fee;
		logic [ID_W-1:0]  id;
	} rec_t;

	typedef struct packed {
		logic load;
		logic pop;
		logic by_fee;
		logic desc;
	} cell_ctrl_t;

endpackage

`default_nettype wire

[hw/rtl/isr_ifs.sv]
// handshake channels of the insertion sort records unit
`default_nettype none

interface isr_in_if;
	logic                      valid;
	logic                      ready;
	logic [isr_pkg::KEY_W-1:0] area_key;
	logic [isr_pkg::KEY_W-1:0] fee_key;
	logic [isr_pkg::ID_W-1:0]  record_id;
	logic                      final_item;

	modport source (output valid, area_key, fee_key, record_id, final_item, input ready);
	modport sink (input valid, area_key, fee_key, record_id, final_item, output ready);
endinterface

interface isr_out_if;
	logic                      valid;
	logic                      ready;
	logic [isr_pkg::ID_W-1:0]  out_record_id;
	logic [isr_pkg::KEY_W-1:0] out_area;
	logic [isr_pkg::KEY_W-1:0] out_fee;
	logic                      out_last;
	logic                      overflowed;

	modport source (output valid, out_record_id, out_area, out_fee, out_last, overflowed,
		input ready);
	modport sink (input valid, out_record_id, out_area, out_fee, out_last, overflowed,
		output ready);
endinterface

interface isr_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [isr_pkg::CFG_IDX_W-1:0]  index;
	logic [isr_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

[hw/rtl/isr_cell.sv]
// one insertion cell: holds a record and shifts it along the row
`default_nettype none

module isr_cell (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire isr_pkg::cell_ctrl_t  ctrl,
	input  wire isr_pkg::rec_t        new_rec,
	input  wire isr_pkg::rec_t        prev_rec,
	input  wire                       prev_valid,
	input  wire                       prev_run,
	input  wire isr_pkg::rec_t        next_rec,
	input  wire                       next_valid,
	input  wire                       run,
	output isr_pkg::rec_t             rec,
	output logic                      valid,
	output logic                      ok
);

	isr_pkg::rec_t                rec_q;
	logic                         valid_q;
	logic [isr_pkg::KEY_W-1:0]    held_key;
	logic [isr_pkg::KEY_W-1:0]    new_key;
	logic                         moves;
	logic                         take;

	assign held_key = ctrl.by_fee ? rec_q.fee : rec_q.area;
	assign new_key  = ctrl.by_fee ? new_rec.fee : new_rec.area;
	assign moves    = ctrl.desc ? (held_key < new_key) : (held_key > new_key);

	// empty cells never block the run of moving cells above the insert point
	assign ok    = moves | ~valid_q;
	assign take  = run | (~valid_q & prev_valid);
	assign rec   = rec_q;
	assign valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.pop) begin
			valid_q <= next_valid;
		end else if (ctrl.load && take) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.pop) begin
			rec_q <= next_rec;
		end else if (ctrl.load && take) begin
			rec_q <= prev_run ? prev_rec : new_rec;
		end
	end

endmodule

`default_nettype wire

[hw/rtl/insertion_sort_records_unit.sv]
// top level: row of insertion cells with config registers and output register
//
// Records arrive on rec_in (valid/ready). Each accepted record is placed at
// once in a row of MAX_ITEMS cells kept in sorted order, by area or fee key,
// ascending or descending, equal keys staying in arrival order. A new record
// is taken every cycle while loading: all cells compare against it in
// parallel and the cells past the insert point step one place up together.
// A record with final_item set closes the set: rec_in drops ready and the
// row shifts down one cell per cycle into the res_out register, the last
// record flagged by out_last. The final item sets the draining flag, and
// the row pops into the output register from then on. The output register
// lets the row keep one item ahead; when res_out stalls the row holds, and
// rec_in opens again the cycle after the last record leaves the row.
// Records arriving with the row full are dropped and overflowed is raised
// on every result of that set. cfg is always ready; index 0 selects the fee
// key, index 1 selects descending order, other indexes are ignored.
// Reset empties the row, clears the drop flag and both config bits.
`default_nettype none

module insertion_sort_records_unit (
	input  wire        clk,
	input  wire        arst_n,
	isr_in_if.sink     rec_in,
	isr_out_if.source  res_out,
	isr_cfg_if.sink    cfg
);

	localparam int N = isr_pkg::MAX_ITEMS;

	logic                 sort_by_fee_q;
	logic                 descending_q;
	logic                 draining_q;
	logic                 drop_q;
	logic                 out_valid_q;
	isr_pkg::rec_t        out_rec_q;
	logic                 out_last_q;
	logic                 out_ovf_q;

	isr_pkg::cell_ctrl_t  ctrl;
	isr_pkg::rec_t        new_rec;
	isr_pkg::rec_t        cell_rec [N];
	logic [N-1:0]         cell_valid;
	logic [N-1:0]         cell_ok;
	logic [N-1:0]         cell_run;
	logic                 accept;
	logic                 full;
	logic                 pop;

	assign rec_in.ready = ~draining_q;
	assign cfg.ready    = 1'b1;
	assign accept       = rec_in.valid & rec_in.ready;
	assign full         = cell_valid[N-1];
	assign pop          = draining_q & (~out_valid_q | res_out.ready);

	assign new_rec.area = rec_in.area_key;
	assign new_rec.fee  = rec_in.fee_key;
	assign new_rec.id   = rec_in.record_id;

	assign ctrl.load   = accept & ~full;
	assign ctrl.pop    = pop;
	assign ctrl.by_fee = sort_by_fee_q;
	assign ctrl.desc   = descending_q;

	genvar i;
	generate
		for (i = 0; i < N; i++) begin : g_cell
			localparam logic [N-1:0] HI_MASK = {N{1'b1}} << i;

			// a cell moves only if it and every held cell above it move
			assign cell_run[i] = cell_valid[i] & (&(cell_ok | ~HI_MASK));

			if (i == 0) begin : g_first
				isr_cell u_cell (
					.clk        (clk),
					.arst_n     (arst_n),
					.ctrl       (ctrl),
					.new_rec    (new_rec),
					.prev_rec   (new_rec),
					.prev_valid (1'b1),
					.prev_run   (1'b0),
					.next_rec   (cell_rec[i+1]),
					.next_valid (cell_valid[i+1]),
					.run        (cell_run[i]),
					.rec        (cell_rec[i]),
					.valid      (cell_valid[i]),
					.ok         (cell_ok[i])
				);
			end else if (i == N-1) begin : g_last
				isr_cell u_cell (
					.clk        (clk),
					.arst_n     (arst_n),
					.ctrl       (ctrl),
					.new_rec    (new_rec),
					.prev_rec   (cell_rec[i-1]),
					.prev_valid (cell_valid[i-1]),
					.prev_run   (cell_run[i-1]),
					.next_rec   (cell_rec[i]),
					.next_valid (1'b0),
					.run        (cell_run[i]),
					.rec        (cell_rec[i]),
					.valid      (cell_valid[i]),
					.ok         (cell_ok[i])
				);
			end else begin : g_mid
				isr_cell u_cell (
					.clk        (clk),
					.arst_n     (arst_n),
					.ctrl       (ctrl),
					.new_rec    (new_rec),
					.prev_rec   (cell_rec[i-1]),
					.prev_valid (cell_valid[i-1]),
					.prev_run   (cell_run[i-1]),
					.next_rec   (cell_rec[i+1]),
					.next_valid (cell_valid[i+1]),
					.run        (cell_run[i]),
					.rec        (cell_rec[i]),
					.valid      (cell_valid[i]),
					.ok         (cell_ok[i])
				);
			end
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sort_by_fee_q <= 1'b0;
			descending_q  <= 1'b0;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				isr_pkg::CFG_SORT_BY_FEE: sort_by_fee_q <= cfg.data[0];
				isr_pkg::CFG_DESCENDING:  descending_q  <= cfg.data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			draining_q  <= 1'b0;
			drop_q      <= 1'b0;
			out_valid_q <= 1'b0;
			out_last_q  <= 1'b0;
			out_ovf_q   <= 1'b0;
		end else begin
			if (accept && full) begin
				drop_q <= 1'b1;
			end
			if (accept && rec_in.final_item) begin
				draining_q <= 1'b1;
			end
			if (pop) begin
				out_valid_q <= 1'b1;
				out_last_q  <= ~cell_valid[1];
				out_ovf_q   <= drop_q;
				// last record of the set leaves the row
				if (!cell_valid[1]) begin
					draining_q <= 1'b0;
					drop_q     <= 1'b0;
				end
			end else if (res_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_rec_q <= cell_rec[0];
		end
	end

	assign res_out.valid         = out_valid_q;
	assign res_out.out_record_id = out_rec_q.id;
	assign res_out.out_area      = out_rec_q.area;
	assign res_out.out_fee       = out_rec_q.fee;
	assign res_out.out_last      = out_last_q;
	assign res_out.overflowed    = out_ovf_q;

endmodule

`default_nettype wire

[hw/rtl/isr_checker.sv]
// port level checks of the insertion sort records unit
`default_nettype none

module isr_checker (
	input wire                      clk,
	input wire                      arst_n,
	input wire                      in_valid,
	input wire                      in_ready,
	input wire                      in_final,
	input wire                      out_valid,
	input wire                      out_ready,
	input wire [isr_pkg::ID_W-1:0]  out_id,
	input wire                      out_last,
	input wire                      out_ovf
);

	// a stalled result keeps its contents
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_id) && $stable(out_last)
			&& $stable(out_ovf))
		else $error("stalled result changed");

	// the final item of a set closes the input side
	a_final_closes: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_final |=> !in_ready)
		else $error("input open after final item");

	// while a run is still being delivered no new record is taken
	a_run_closed: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_last |-> !in_ready)
		else $error("input open during a run");

	// a result appears only while the input is closed or just after it
	a_out_after_final: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result without a closed set");

endmodule

bind insertion_sort_records_unit isr_checker u_isr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (rec_in.valid),
	.in_ready  (rec_in.ready),
	.in_final  (rec_in.final_item),
	.out_valid (res_out.valid),
	.out_ready (res_out.ready),
	.out_id    (res_out.out_record_id),
	.out_last  (res_out.out_last),
	.out_ovf   (res_out.overflowed)
);

`default_nettype wire

[verif/insertion_sort_records_unit_test.sv]
// testbench of the insertion sort records unit: random sets against a sorting row model
`timescale 1ns / 100ps

module insertion_sort_records_unit_test;

	localparam int STALL_LIMIT = 2000;
	localparam int ROW_SETTLE  = 4;
	localparam int DRAIN_TAIL  = 8;
	localparam int RANDOM_ITEMS = 460;
	localparam int CALM_FROM   = 170;
	localparam int CALM_TO     = 280;

	typedef struct packed {
		isr_pkg::rec_t rec;
		logic closes_set;
	} rec_item_t;

	typedef struct packed {
		isr_pkg::rec_t rec;
		logic last;
		logic dropped;
	} sorted_rec_t;

	typedef struct packed {
		logic [isr_pkg::CFG_IDX_W-1:0]  index;
		logic [isr_pkg::CFG_DATA_W-1:0] data;
	} reg_write_t;

	typedef enum int {KEYS_WIDE, KEYS_CLASHING, KEYS_EXTREME, KEYS_NEAR} key_spread_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic       rec_valid = 1'b0;
	rec_item_t  rec_drive = '0;
	logic       res_ready = 1'b0;
	logic       cfg_valid = 1'b0;
	reg_write_t cfg_drive = '0;

	isr_in_if  rec_if ();
	isr_out_if res_if ();
	isr_cfg_if cfg_if ();

	assign rec_if.valid      = rec_valid;
	assign rec_if.area_key   = rec_drive.rec.area;
	assign rec_if.fee_key    = rec_drive.rec.fee;
	assign rec_if.record_id  = rec_drive.rec.id;
	assign rec_if.final_item = rec_drive.closes_set;
	assign res_if.ready      = res_ready;
	assign cfg_if.valid      = cfg_valid;
	assign cfg_if.index      = cfg_drive.index;
	assign cfg_if.data       = cfg_drive.data;

	insertion_sort_records_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.rec_in  (rec_if),
		.res_out (res_if),
		.cfg     (cfg_if)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	rec_item_t   records_pending[$];
	reg_write_t  reg_writes_pending[$];
	sorted_rec_t sorted_due[$];

	// model of the row of cells
	isr_pkg::rec_t row_model [isr_pkg::MAX_ITEMS];
	int   row_fill = 0;
	logic row_dropped = 1'b0;
	logic key_fee = 1'b0;
	logic key_desc = 1'b0;

	int   errors = 0;
	int   items_sent = 0;
	int   records_taken = 0;
	logic calm;
	int   quiet_cycles = 0;
	sorted_rec_t due;

	// no idling while this stretch of records goes through
	assign calm = records_taken >= CALM_FROM && records_taken < CALM_TO;

	function automatic logic [isr_pkg::KEY_W-1:0] key_of(isr_pkg::rec_t r);
		return key_fee ? r.fee : r.area;
	endfunction

	task automatic sort_record(rec_item_t item);
		int pos;
		logic [isr_pkg::KEY_W-1:0] k;
		sorted_rec_t result;
		k = key_of(item.rec);
		if (row_fill < isr_pkg::MAX_ITEMS) begin
			pos = row_fill;
			// equal keys stop the shift, so arrival order is kept
			while (pos > 0 && (key_desc ? key_of(row_model[pos-1]) < k
					: key_of(row_model[pos-1]) > k)) begin
				row_model[pos] = row_model[pos-1];
				pos--;
			end
			row_model[pos] = item.rec;
			row_fill++;
		end else begin
			row_dropped = 1'b1;
		end
		if (item.closes_set) begin
			for (int i = 0; i < row_fill; i++) begin
				result = '{row_model[i], i == row_fill - 1, row_dropped};
				sorted_due = {sorted_due, result};
			end
			row_fill = 0;
			row_dropped = 1'b0;
		end
	endtask

	task automatic apply_reg_write(reg_write_t w);
		if (w.index == isr_pkg::CFG_SORT_BY_FEE)
			key_fee = w.data[0];
		else if (w.index == isr_pkg::CFG_DESCENDING)
			key_desc = w.data[0];
	endtask

	task automatic check_field(string name, logic [isr_pkg::KEY_W-1:0] want,
			logic [isr_pkg::KEY_W-1:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s expected %h actual %h", $time, name, want, got);
		end
	endtask

	// record driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (rec_valid && rec_if.ready) begin
				sort_record(records_pending.pop_front());
				records_taken++;
			end
			if (!rec_valid || rec_if.ready) begin
				if (records_pending.size() != 0 && (calm || $urandom_range(0, 99) >= 33)) begin
					rec_valid <= 1'b1;
					rec_drive <= records_pending[0];
				end else begin
					rec_valid <= 1'b0;
				end
			end
		end
	end

	// register write driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_if.ready)
				apply_reg_write(reg_writes_pending.pop_front());
			if (!cfg_valid || cfg_if.ready) begin
				if (reg_writes_pending.size() != 0 && (calm || $urandom_range(0, 99) >= 33)) begin
					cfg_valid <= 1'b1;
					cfg_drive <= reg_writes_pending[0];
				end else begin
					cfg_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (res_if.valid && res_ready) begin
				if (sorted_due.size() == 0) begin
					errors++;
					$display("%0t: result expected none actual id %h", $time,
						res_if.out_record_id);
				end else begin
					due = sorted_due.pop_front();
					check_field("out_record_id", isr_pkg::KEY_W'(due.rec.id),
						isr_pkg::KEY_W'(res_if.out_record_id));
					check_field("out_area", due.rec.area, res_if.out_area);
					check_field("out_fee", due.rec.fee, res_if.out_fee);
					check_field("out_last", isr_pkg::KEY_W'(due.last),
						isr_pkg::KEY_W'(res_if.out_last));
					check_field("overflowed", isr_pkg::KEY_W'(due.dropped),
						isr_pkg::KEY_W'(res_if.overflowed));
				end
			end
			res_ready <= calm || $urandom_range(0, 99) >= 33;
		end
	end

	// watchdog on cycles with work outstanding and no handshake
	always @(posedge clk) begin
		if (arst_n) begin
			if ((rec_valid && rec_if.ready) || (res_if.valid && res_ready)
					|| (cfg_valid && cfg_if.ready)) begin
				quiet_cycles <= 0;
			end else if (records_pending.size() != 0 || sorted_due.size() != 0
					|| reg_writes_pending.size() != 0) begin
				quiet_cycles <= quiet_cycles + 1;
				if (quiet_cycles >= STALL_LIMIT) begin
					$display("simulation failed");
					$finish;
				end
			end
		end
	end

	function automatic logic [isr_pkg::KEY_W-1:0] pick_key(key_spread_t spread);
		case (spread)
			KEYS_CLASHING: return isr_pkg::KEY_W'($urandom_range(0, 3));
			KEYS_EXTREME:  return $urandom_range(0, 1) ? '1 : '0;
			KEYS_NEAR:     return {16'($urandom_range(0, 2)), 16'($urandom())};
			default:       return $urandom();
		endcase
	endfunction

	task automatic push_record(logic [isr_pkg::KEY_W-1:0] area,
			logic [isr_pkg::KEY_W-1:0] fee, logic [isr_pkg::ID_W-1:0] id, logic closes);
		rec_item_t item;
		item = '{'{area, fee, id}, closes};
		records_pending = {records_pending, item};
		items_sent++;
	endtask

	task automatic push_set(int n, logic closes);
		key_spread_t area_spread;
		key_spread_t fee_spread;
		area_spread = key_spread_t'($urandom_range(0, 3));
		fee_spread = key_spread_t'($urandom_range(0, 3));
		for (int i = 0; i < n; i++)
			push_record(pick_key(area_spread), pick_key(fee_spread),
				isr_pkg::ID_W'($urandom()), closes && i == n - 1);
	endtask

	// waits until the row holds no work in flight
	task automatic settle_row();
		while (records_pending.size() != 0 || rec_valid || sorted_due.size() != 0)
			@(posedge clk);
		repeat (ROW_SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic [isr_pkg::CFG_IDX_W-1:0] index,
			logic [isr_pkg::CFG_DATA_W-1:0] data);
		reg_write_t w;
		settle_row();
		w = '{index, data};
		reg_writes_pending = {reg_writes_pending, w};
		while (reg_writes_pending.size() != 0 || cfg_valid)
			@(posedge clk);
	endtask

	task automatic write_random_reg();
		if ($urandom_range(0, 7) == 0)
			write_reg(isr_pkg::CFG_IDX_W'($urandom_range(2, 255)), $urandom());
		else
			write_reg($urandom_range(0, 1) ? isr_pkg::CFG_DESCENDING
				: isr_pkg::CFG_SORT_BY_FEE, $urandom());
	endtask

	initial begin
		int n;
		int split;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// area ascending after reset: extremes and ties
		push_record('1, '0, '0, 1'b0);
		push_record('0, '1, '1, 1'b0);
		push_record('1, 32'd1, 16'd1, 1'b0);
		push_record('0, 32'd2, 16'd2, 1'b1);
		// set of one record
		push_record(32'h8000_0000, 32'h7FFF_FFFF, 16'h1234, 1'b1);
		// order flipped while the set is loading
		push_record(32'd10, $urandom(), 16'd20, 1'b0);
		push_record(32'd30, $urandom(), 16'd21, 1'b0);
		write_reg(isr_pkg::CFG_DESCENDING, 32'h0000_0003);
		push_record(32'd20, $urandom(), 16'd22, 1'b0);
		push_record(32'd40, $urandom(), 16'd23, 1'b0);
		push_record(32'd10, $urandom(), 16'd24, 1'b1);
		// fee descending, upper bits of writes ignored, unknown indexes ignored
		write_reg(isr_pkg::CFG_SORT_BY_FEE, 32'h8000_0001);
		write_reg(isr_pkg::CFG_IDX_W'(2), '1);
		write_reg('1, '1);
		push_record($urandom(), 32'd5, 16'd10, 1'b0);
		push_record($urandom(), '1, 16'd11, 1'b0);
		push_record($urandom(), 32'd5, 16'd12, 1'b0);
		push_record($urandom(), '0, 16'd13, 1'b0);
		push_record($urandom(), '1, 16'd14, 1'b1);
		// fee ascending
		write_reg(isr_pkg::CFG_DESCENDING, 32'hFFFF_FFFE);
		push_record($urandom(), 32'd7, 16'hAAAA, 1'b0);
		push_record($urandom(), 32'd3, 16'h5555, 1'b0);
		push_record($urandom(), 32'd7, 16'hFFFE, 1'b0);
		push_record($urandom(), 32'd0, 16'h0001, 1'b1);

		items_sent = 0;
		while (items_sent < RANDOM_ITEMS) begin
			if ($urandom_range(0, 3) == 0)
				write_random_reg();
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 40) : $urandom_range(1, 10);
			if (n > 1 && $urandom_range(0, 7) == 0) begin
				split = $urandom_range(1, n - 1);
				push_set(split, 1'b0);
				write_random_reg();
				push_set(n - split, 1'b1);
			end else begin
				push_set(n, 1'b1);
			end
		end

		while (records_pending.size() != 0 || sorted_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_TAIL) @(posedge clk);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

[filelist.f]
hw/rtl/isr_pkg.sv
hw/rtl/isr_ifs.sv
hw/rtl/isr_cell.sv
hw/rtl/insertion_sort_records_unit.sv
hw/rtl/isr_checker.sv
verif/insertion_sort_records_unit_test.sv
